// ----- rtl/core/assert_macros.svh -----
// Assertion macros for the checker file of the line rasterizer.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is active.
`define ASSERT_SAME(label, clk, rst_n, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is active.
`define ASSERT_NEXT(label, clk, rst_n, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error(msg);

`endif

// ----- rtl/core/dda_pkg.sv -----
// Types and constants shared by the DDA line rasterizer modules.
`timescale 1ns / 1ps
`default_nettype none
package dda_pkg;

    localparam int COORD_BITS    = 6;
    localparam int FRAC_BITS_DEF = 16;

    typedef logic [COORD_BITS-1:0] t_coord;

    typedef struct packed {
        t_coord x_start;
        t_coord y_start;
        t_coord x_end;
        t_coord y_end;
    } t_seg_in;

    typedef struct packed {
        t_coord px;
        t_coord py;
        logic   last;
    } t_pt_out;

    typedef struct packed {
        logic load;
        logic div_step;
        logic emit_step;
    } t_dp_cmd;

    typedef struct packed {
        logic zero_len;
        logic div_last;
        logic emit_last;
    } t_dp_stat;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_EMIT
    } t_state;

endpackage
`default_nettype wire

// ----- rtl/core/dda_ctrl.sv -----
// Controller state machine: load, divide, then emit points.
`timescale 1ns / 1ps
`default_nettype none
module dda_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  dda_pkg::t_dp_stat i_stat,
    output dda_pkg::t_dp_cmd  o_cmd,
    output logic              o_busy
);
    import dda_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_busy  = 1'b1;
        unique case (r_state)
            ST_IDLE: begin
                o_busy = 1'b0;
                if (i_start) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_DIV;
                end
            end
            ST_DIV: begin
                // a zero-length segment skips the divide, increment stays zero
                if (i_stat.zero_len) begin
                    n_state = ST_EMIT;
                end else begin
                    o_cmd.div_step = 1'b1;
                    if (i_stat.div_last) begin
                        n_state = ST_EMIT;
                    end
                end
            end
            ST_EMIT: begin
                o_cmd.emit_step = 1'b1;
                if (i_stat.emit_last) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule
`default_nettype wire

// ----- rtl/core/dda_dp.sv -----
// Datapath: segment setup, restoring divider and point accumulator.
`timescale 1ns / 1ps
`default_nettype none
module dda_dp #(
    parameter int FRAC_BITS = dda_pkg::FRAC_BITS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  dda_pkg::t_seg_in  i_seg,
    input  dda_pkg::t_dp_cmd  i_cmd,
    output dda_pkg::t_dp_stat o_stat,
    output logic              o_valid,
    output dda_pkg::t_pt_out  o_pt
);
    import dda_pkg::*;

    localparam int CB = COORD_BITS;
    localparam int QW = FRAC_BITS + 1;
    localparam int AW = COORD_BITS + FRAC_BITS + 1;
    localparam int CW = $clog2(FRAC_BITS + 1);

    // setup from the incoming word
    logic   x_neg, y_neg, x_maj;
    t_coord adx, ady, major, minor;

    always_comb begin
        x_neg = i_seg.x_end < i_seg.x_start;
        y_neg = i_seg.y_end < i_seg.y_start;
        adx   = x_neg ? i_seg.x_start - i_seg.x_end : i_seg.x_end - i_seg.x_start;
        ady   = y_neg ? i_seg.y_start - i_seg.y_end : i_seg.y_end - i_seg.y_start;
        x_maj = adx >= ady;
        major = x_maj ? adx : ady;
        minor = x_maj ? ady : adx;
    end

    t_coord          r_xs, r_ys, r_major, r_i;
    logic            r_xneg, r_yneg, r_xmaj;
    logic [CB:0]     r_rem;
    logic [QW-1:0]   r_q;
    logic [CW-1:0]   r_cnt;
    logic [AW-1:0]   r_acc;
    logic            r_valid;
    t_pt_out         r_pt;

    // divider step: one quotient bit per cycle, remainder after the subtract always below major
    logic        div_ge;
    logic [CB:0] div_diff, div_rem;

    always_comb begin
        div_ge   = r_rem >= {1'b0, r_major};
        div_diff = r_rem - {1'b0, r_major};
        div_rem  = div_ge ? div_diff : r_rem;
    end

    // point for the current step
    t_coord off, dx, dy, px, py;

    always_comb begin
        off = r_acc[FRAC_BITS +: CB];
        dx  = r_xmaj ? r_i : off;
        dy  = r_xmaj ? off : r_i;
        px  = r_xneg ? r_xs - dx : r_xs + dx;
        py  = r_yneg ? r_ys - dy : r_ys + dy;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_xs    <= i_seg.x_start;
            r_ys    <= i_seg.y_start;
            r_xneg  <= x_neg;
            r_yneg  <= y_neg;
            r_xmaj  <= x_maj;
            r_major <= major;
            r_rem   <= {1'b0, minor};
            r_q     <= '0;
            r_cnt   <= '0;
            r_i     <= '0;
            // accumulator starts at one half for round half up
            r_acc   <= {{(AW-FRAC_BITS){1'b0}}, 1'b1, {(FRAC_BITS-1){1'b0}}};
        end
        if (i_cmd.div_step) begin
            r_rem <= {div_rem[CB-1:0], 1'b0};
            r_q   <= {r_q[QW-2:0], div_ge};
            r_cnt <= r_cnt + CW'(1);
        end
        if (i_cmd.emit_step) begin
            r_acc   <= r_acc + {{(AW-QW){1'b0}}, r_q};
            r_i     <= r_i + t_coord'(1);
            r_pt.px <= px;
            r_pt.py <= py;
            r_pt.last <= (r_i == r_major);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_cmd.emit_step;
        end
    end

    always_comb begin
        o_stat.zero_len  = (r_major == '0);
        o_stat.div_last  = (r_cnt == CW'(FRAC_BITS));
        o_stat.emit_last = (r_i == r_major);
    end

    assign o_valid = r_valid;
    assign o_pt    = r_pt;

endmodule
`default_nettype wire

// ----- rtl/core/dda_line_rasterizer.sv -----
// DDA line rasterizer top level: controller plus datapath.
// Per segment: the accept cycle loads, the divider then forms FRAC_BITS+1 quotient bits
// (skipped for a zero-length segment), then major+1 points follow at one per cycle.
// Points are registered outputs; no new word is accepted before the last point of the
// previous segment is strobed.
// Points are single-cycle strobes, receiver cannot stall. Sync active-low reset.
`timescale 1ns / 1ps
`default_nettype none
module dda_line_rasterizer #(
    parameter int FRAC_BITS = dda_pkg::FRAC_BITS_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             start,
    output logic             busy,
    input  dda_pkg::t_seg_in i_seg,
    output logic             o_valid,
    output dda_pkg::t_pt_out o_pt
);
    import dda_pkg::*;

    t_dp_cmd  cmd;
    t_dp_stat stat;

    dda_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_stat  (stat),
        .o_cmd   (cmd),
        .o_busy  (busy)
    );

    dda_dp #(
        .FRAC_BITS (FRAC_BITS)
    ) u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_seg   (i_seg),
        .i_cmd   (cmd),
        .o_stat  (stat),
        .o_valid (o_valid),
        .o_pt    (o_pt)
    );

endmodule
`default_nettype wire

// ----- rtl/core/dda_checker.sv -----
// Port-level checker for the DDA line rasterizer, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module dda_checker (
    input wire logic             i_clk,
    input wire logic             i_rst_n,
    input wire logic             start,
    input wire logic             busy,
    input wire logic             o_valid,
    input wire dda_pkg::t_pt_out o_pt
);
    import dda_pkg::*;

    `ASSERT_NEXT(a_start_busy, i_clk, i_rst_n, start && !busy, busy, "accepted word not busy")
    `ASSERT_SAME(a_last_idle, i_clk, i_rst_n, o_valid && o_pt.last, !busy, "busy after last point")
    `ASSERT_NEXT(a_points_run, i_clk, i_rst_n, o_valid && !o_pt.last, o_valid, "gap in points")
    `ASSERT_NEXT(a_idle_quiet, i_clk, i_rst_n, !busy && !start, !o_valid, "point while idle")
    `ASSERT_SAME(a_valid_src, i_clk, i_rst_n, o_valid, $past(busy), "point without work")

endmodule

bind dda_line_rasterizer dda_checker u_dda_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .start   (start),
    .busy    (busy),
    .o_valid (o_valid),
    .o_pt    (o_pt)
);
`default_nettype wire
